[design/truetype_push_data_tokenizer_assert.svh]
// Assertion macros shared by the tokenizer checker.
// No dependencies; include by bare file name.
`ifndef TRUETYPE_PUSH_DATA_TOKENIZER_ASSERT_SVH
`define TRUETYPE_PUSH_DATA_TOKENIZER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define TTPDT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, off while reset is asserted
`define TTPDT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, checked through reset as well
`define TTPDT_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("tokenizer assertion failed");

`endif

[design/ttpdt_pkg.sv]
// Types and constants for the TrueType push-data tokenizer.
// No dependencies.
package ttpdt_pkg;

    localparam logic [7:0] OP_NPUSHB   = 8'h40;
    localparam logic [7:0] OP_NPUSHW   = 8'h41;
    localparam logic [7:0] PUSH_MASK   = 8'hf8;
    localparam logic [7:0] PUSHB_BASE  = 8'hb0;
    localparam logic [7:0] PUSHW_BASE  = 8'hb8;
    localparam logic [2:0] PUSH_N_MASK = 3'd7;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_CNT_B  = 3'd1,
        PH_CNT_W  = 3'd2,
        PH_BYTE   = 3'd3,
        PH_WHI    = 3'd4,
        PH_WLO    = 3'd5
    } t_phase;

    localparam logic [2:0] KIND_OP   = 3'd0;
    localparam logic [2:0] KIND_CNT  = 3'd1;
    localparam logic [2:0] KIND_BYTE = 3'd2;
    localparam logic [2:0] KIND_WHI  = 3'd3;
    localparam logic [2:0] KIND_WLO  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        truncated;
        logic        end_of_program;
    } t_result;

endpackage

[design/truetype_push_data_tokenizer.sv]
// TrueType push-data tokenizer: labels each bytecode byte and assembles pushed words.
// Depends on ttpdt_pkg.
// Output: each result word is registered in the output register, or first in the skid register while output stalls.
// Throughput: one byte per cycle while the skid register is empty; the parse state updates in the accept cycle.
// A skid register keeps s_axis_tready registered, so input flows while output stalls once.
// Reset: synchronous, active low; clears phase, count, saved high byte and valid flags.
module truetype_push_data_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] value
    output logic [7:0]  m_axis_tuser,   // [2:0] kind, [3] truncated, [7:4] zero
    output logic        m_axis_tlast    // end_of_program
);

    ttpdt_pkg::t_phase  r_phase, n_phase;
    logic [7:0]         r_items, n_items;
    logic [7:0]         r_saved, n_saved;
    ttpdt_pkg::t_result r_out, r_skid, w_res;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    logic               w_acc, w_take, w_out_free;
    logic [7:0]         w_b;
    logic [7:0]         w_items_dec;
    logic [7:0]         w_push_n;

    assign s_axis_tready = !r_skid_valid;
    assign w_acc         = s_axis_tvalid && !r_skid_valid;
    assign w_take        = r_out_valid && m_axis_tready;
    assign w_out_free    = !r_out_valid || w_take;

    assign w_b         = s_axis_tdata;
    assign w_items_dec = r_items - 8'd1;
    assign w_push_n    = {5'd0, w_b[2:0] & ttpdt_pkg::PUSH_N_MASK} + 8'd1;

    // parse step for the byte on the slave side
    always_comb begin
        n_phase         = r_phase;
        n_items         = r_items;
        n_saved         = r_saved;
        w_res.kind      = ttpdt_pkg::KIND_OP;
        w_res.value     = {8'd0, w_b};
        w_res.truncated = 1'b0;
        w_res.end_of_program = s_axis_tlast;
        case (r_phase)
            ttpdt_pkg::PH_CNT_B, ttpdt_pkg::PH_CNT_W: begin
                w_res.kind = ttpdt_pkg::KIND_CNT;
                n_items    = w_b;
                if (w_b == 8'd0) begin
                    n_phase = ttpdt_pkg::PH_OPCODE;
                end else if (r_phase == ttpdt_pkg::PH_CNT_B) begin
                    n_phase = ttpdt_pkg::PH_BYTE;
                end else begin
                    n_phase = ttpdt_pkg::PH_WHI;
                end
            end
            ttpdt_pkg::PH_BYTE: begin
                w_res.kind = ttpdt_pkg::KIND_BYTE;
                n_items    = w_items_dec;
                if (w_items_dec == 8'd0) begin
                    n_phase = ttpdt_pkg::PH_OPCODE;
                end
            end
            ttpdt_pkg::PH_WHI: begin
                w_res.kind = ttpdt_pkg::KIND_WHI;
                n_saved    = w_b;
                n_phase    = ttpdt_pkg::PH_WLO;
            end
            ttpdt_pkg::PH_WLO: begin
                w_res.kind  = ttpdt_pkg::KIND_WLO;
                w_res.value = {r_saved, w_b};
                n_items     = w_items_dec;
                n_phase     = (w_items_dec == 8'd0) ? ttpdt_pkg::PH_OPCODE
                                                    : ttpdt_pkg::PH_WHI;
            end
            default: begin
                n_phase = ttpdt_pkg::PH_OPCODE;
                if (w_b == ttpdt_pkg::OP_NPUSHB) begin
                    n_phase = ttpdt_pkg::PH_CNT_B;
                end else if (w_b == ttpdt_pkg::OP_NPUSHW) begin
                    n_phase = ttpdt_pkg::PH_CNT_W;
                end else if ((w_b & ttpdt_pkg::PUSH_MASK) == ttpdt_pkg::PUSHB_BASE) begin
                    n_items = w_push_n;
                    n_phase = ttpdt_pkg::PH_BYTE;
                end else if ((w_b & ttpdt_pkg::PUSH_MASK) == ttpdt_pkg::PUSHW_BASE) begin
                    n_items = w_push_n;
                    n_phase = ttpdt_pkg::PH_WHI;
                end
            end
        endcase
        // end of program: flag pending push data, back to opcode
        if (s_axis_tlast) begin
            w_res.truncated = (n_phase != ttpdt_pkg::PH_OPCODE);
            n_phase         = ttpdt_pkg::PH_OPCODE;
            n_items         = 8'd0;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_acc;
            end
        end else if (w_acc) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ttpdt_pkg::PH_OPCODE;
            r_items      <= 8'd0;
            r_saved      <= 8'd0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (w_acc) begin
                r_phase <= n_phase;
                r_items <= n_items;
                r_saved <= n_saved;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_acc) begin
                r_out <= w_res;
            end
        end else if (w_acc) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = {4'd0, r_out.truncated, r_out.kind};
    assign m_axis_tlast  = r_out.end_of_program;

endmodule

[design/ttpdt_checker.sv]
// Port-level checks for the TrueType push-data tokenizer, bound to the top level.
// Depends on ttpdt_pkg and truetype_push_data_tokenizer_assert.svh.
`include "truetype_push_data_tokenizer_assert.svh"

module ttpdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [7:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `TTPDT_ASSERT_NEXT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n, !m_axis_tvalid)

    `TTPDT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    `TTPDT_ASSERT_IMPLY(a_trunc_only_at_end, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[3], m_axis_tlast)

    `TTPDT_ASSERT_IMPLY(a_kind_legal, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tuser[2:0] == ttpdt_pkg::KIND_OP || m_axis_tuser[2:0] == ttpdt_pkg::KIND_CNT || m_axis_tuser[2:0] == ttpdt_pkg::KIND_BYTE || m_axis_tuser[2:0] == ttpdt_pkg::KIND_WHI || m_axis_tuser[2:0] == ttpdt_pkg::KIND_WLO) && m_axis_tuser[7:4] == 4'd0)

endmodule

bind truetype_push_data_tokenizer ttpdt_checker u_ttpdt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
